>>> rtl/core/dpcsr_pkg.sv
// ----------------------------------------------------------------------------
// dpcsr_pkg
// Shared constants for the dual pulse capture block with its SPI responder.
// ----------------------------------------------------------------------------
package dpcsr_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int TIMER_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int REPLY_ST_W  = 3;

    typedef logic [REPLY_ST_W-1:0] t_reply_st;

    // SPI command bytes
    localparam logic [BYTE_W-1:0] CMD_TIMER = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_WIDTH = 8'h02;

    // Reply sequencer states
    localparam t_reply_st ST_CMD    = 3'd0;
    localparam t_reply_st ST_TMR_HI = 3'd1;
    localparam t_reply_st ST_CH1_HI = 3'd2;
    localparam t_reply_st ST_CH2_LO = 3'd3;
    localparam t_reply_st ST_CH2_HI = 3'd4;

    // Item kind carried in s_axis_tuser
    localparam logic MODE_PINS = 1'b0;
    localparam logic MODE_SPI  = 1'b1;

endpackage

>>> rtl/core/dual_pulse_capture_spi_readout.sv
// ----------------------------------------------------------------------------
// dual_pulse_capture_spi_readout
// Two-channel pulse width capture with an SPI command reply sequencer.
// ----------------------------------------------------------------------------
// Each input beat is either a pin sample (tuser 0) or a received SPI byte
// (tuser 1), and each gives exactly one output beat. A beat is registered at
// the input, then processed combinationally into the capture state and the
// output register, so one beat per clock is sustained; only output
// backpressure slows it. A rising edge on a channel latches the timer as
// its start time, a falling edge stores the width modulo 2^16 and, with
// mirroring on, copies its high byte to the duty output. SPI command 0x01
// replies timer low byte then the latched high byte; 0x02 replies channel
// one low, high, then channel two low, high; anything else replies 0.
module dual_pulse_capture_spi_readout
    import dpcsr_pkg::*;
#(
    parameter logic [7:0] DUTY_RESET = 8'd117
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,   // mirror_enable
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] pin_levels, [17:2] timer_value, [25:18] spi_byte, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] spi_reply, [23:8] channel_one_width, [39:24] channel_two_width,
    // [47:40] duty_a, [55:48] duty_b
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] spi_reply_valid
    output logic                   m_axis_tuser
);

    // input register
    logic               r_in_valid;
    logic               r_in_mode;
    logic [1:0]         r_in_pins;
    logic [TIMER_W-1:0] r_in_timer;
    logic [BYTE_W-1:0]  r_in_byte;

    // capture and sequencer state
    logic               r_mirror_en;
    logic [TIMER_W-1:0] r_one_start, n_one_start;
    logic [TIMER_W-1:0] r_two_start, n_two_start;
    logic               r_one_level, n_one_level;
    logic               r_two_level, n_two_level;
    logic [TIMER_W-1:0] r_one_width, n_one_width;
    logic [TIMER_W-1:0] r_two_width, n_two_width;
    t_reply_st          r_reply_st,  n_reply_st;
    logic [BYTE_W-1:0]  r_tmr_hi,    n_tmr_hi;
    logic [BYTE_W-1:0]  r_duty_a,    n_duty_a;
    logic [BYTE_W-1:0]  r_duty_b,    n_duty_b;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_reply, n_out_reply;
    logic               r_out_spi;

    logic w_out_free;
    logic w_proc;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_spi;
    assign m_axis_tdata  = {r_duty_b, r_duty_a, r_two_width, r_one_width, r_out_reply};

    always_comb begin
        n_one_start = r_one_start;
        n_two_start = r_two_start;
        n_one_level = r_one_level;
        n_two_level = r_two_level;
        n_one_width = r_one_width;
        n_two_width = r_two_width;
        n_reply_st  = r_reply_st;
        n_tmr_hi    = r_tmr_hi;
        n_duty_a    = r_duty_a;
        n_duty_b    = r_duty_b;
        n_out_reply = '0;
        if (r_in_mode == MODE_PINS) begin
            if (r_in_pins[0] != r_one_level) begin
                n_one_level = r_in_pins[0];
                if (r_in_pins[0]) begin
                    n_one_start = r_in_timer;
                end else begin
                    n_one_width = r_in_timer - r_one_start;
                    if (r_mirror_en) begin
                        n_duty_a = n_one_width[TIMER_W-1 -: BYTE_W];
                    end
                end
            end
            if (r_in_pins[1] != r_two_level) begin
                n_two_level = r_in_pins[1];
                if (r_in_pins[1]) begin
                    n_two_start = r_in_timer;
                end else begin
                    n_two_width = r_in_timer - r_two_start;
                    if (r_mirror_en) begin
                        n_duty_b = n_two_width[TIMER_W-1 -: BYTE_W];
                    end
                end
            end
        end else begin
            unique case (r_reply_st)
                ST_TMR_HI: begin
                    n_out_reply = r_tmr_hi;
                    n_reply_st  = ST_CMD;
                end
                ST_CH1_HI: begin
                    n_out_reply = r_one_width[TIMER_W-1 -: BYTE_W];
                    n_reply_st  = ST_CH2_LO;
                end
                ST_CH2_LO: begin
                    n_out_reply = r_two_width[BYTE_W-1:0];
                    n_reply_st  = ST_CH2_HI;
                end
                ST_CH2_HI: begin
                    n_out_reply = r_two_width[TIMER_W-1 -: BYTE_W];
                    n_reply_st  = ST_CMD;
                end
                default: begin
                    // command mode; unused codes land here too
                    if (r_in_byte == CMD_TIMER) begin
                        n_out_reply = r_in_timer[BYTE_W-1:0];
                        n_tmr_hi    = r_in_timer[TIMER_W-1 -: BYTE_W];
                        n_reply_st  = ST_TMR_HI;
                    end else if (r_in_byte == CMD_WIDTH) begin
                        n_out_reply = r_one_width[BYTE_W-1:0];
                        n_reply_st  = ST_CH1_HI;
                    end else begin
                        n_reply_st  = ST_CMD;
                    end
                end
            endcase
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mirror_en <= 1'b1;
            r_one_start <= '0;
            r_two_start <= '0;
            r_one_level <= 1'b0;
            r_two_level <= 1'b0;
            r_one_width <= '0;
            r_two_width <= '0;
            r_reply_st  <= ST_CMD;
            r_tmr_hi    <= '0;
            r_duty_a    <= DUTY_RESET;
            r_duty_b    <= DUTY_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_mirror_en <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_one_start <= n_one_start;
                r_two_start <= n_two_start;
                r_one_level <= n_one_level;
                r_two_level <= n_two_level;
                r_one_width <= n_one_width;
                r_two_width <= n_two_width;
                r_reply_st  <= n_reply_st;
                r_tmr_hi    <= n_tmr_hi;
                r_duty_a    <= n_duty_a;
                r_duty_b    <= n_duty_b;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode  <= s_axis_tuser;
            r_in_pins  <= s_axis_tdata[1:0];
            r_in_timer <= s_axis_tdata[2 +: TIMER_W];
            r_in_byte  <= s_axis_tdata[2+TIMER_W +: BYTE_W];
        end
        if (w_proc) begin
            r_out_reply <= n_out_reply;
            r_out_spi   <= r_in_mode;
        end
    end

    // a pin sample never moves the reply sequencer
    a_pins_keep_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_mode == MODE_PINS) |=> $stable(r_reply_st))
        else $error("reply state changed on a pin sample");

    // an SPI byte never touches the captured widths
    a_spi_keep_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_mode == MODE_SPI) |=> ($stable(r_one_width) && $stable(r_two_width)))
        else $error("width changed on an SPI byte");

    // pin sample beats carry a zero reply
    a_pin_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_spi) |-> (r_out_reply == '0))
        else $error("nonzero reply on a pin sample beat");

    // duty outputs hold while mirroring is off
    a_duty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_mirror_en && !i_cfg_wr_en) |=> ($stable(r_duty_a) && $stable(r_duty_b)))
        else $error("duty changed with mirroring off");

    // both stages full and output stalled means no new beat
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("beat accepted with the pipeline full");

endmodule
